// File: hw/rtl/fcpu_pkg.sv
`timescale 1ns / 1ps
package fcpu_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_WALK_SPEED   = 2'd0,
        REG_SPRINT_SPEED = 2'd1,
        REG_MOUSE_SENS   = 2'd2
    } cfg_index_t;

    localparam logic [15:0] WALK_SPEED_RESET   = 16'd640;
    localparam logic [15:0] SPRINT_SPEED_RESET = 16'd1280;
    localparam logic [15:0] MOUSE_SENS_RESET   = 16'd6554;

    // Angles in 1/128 degree
    localparam logic [15:0] YAW_FULL          = 16'd46080;
    localparam logic [17:0] YAW_HALF          = 18'd23040;
    localparam logic [17:0] YAW_QUARTER       = 18'd11520;
    localparam logic [17:0] YAW_THREE_QUARTER = 18'd34560;
    localparam logic [15:0] YAW_RESET         = 16'd34560;
    localparam logic signed [24:0] PITCH_LIMIT = 25'sd11392;
    // 256 turns, added to make a negative yaw sum positive
    localparam logic signed [25:0] YAW_BIAS   = 26'sd11796480;
    localparam int          WRAP_STEPS        = 10;

    // CORDIC in Q2.30
    localparam int                 CORDIC_STEPS    = 16;
    localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;

    function automatic logic signed [31:0] atan_lut(input logic [3:0] i);
        logic signed [31:0] v;
        begin
            case (i)
                4'd0:    v = 32'sd47185920;
                4'd1:    v = 32'sd27855475;
                4'd2:    v = 32'sd14718068;
                4'd3:    v = 32'sd7471121;
                4'd4:    v = 32'sd3750058;
                4'd5:    v = 32'sd1876857;
                4'd6:    v = 32'sd938658;
                4'd7:    v = 32'sd469357;
                4'd8:    v = 32'sd234682;
                4'd9:    v = 32'sd117342;
                4'd10:   v = 32'sd58671;
                4'd11:   v = 32'sd29335;
                4'd12:   v = 32'sd14668;
                4'd13:   v = 32'sd7334;
                4'd14:   v = 32'sd3667;
                default: v = 32'sd1834;
            endcase
            return v;
        end
    endfunction

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;
        logic       pre;
        logic       move;
        logic       sat;
        logic       wrap;
        logic       cinit;
        logic       cstep;
        logic       cstore;
        logic       csel;
        logic       vmul;
        logic       publish;
        logic [4:0] cnt;
    } cmd_t;

endpackage

// File: hw/rtl/fcpu_ctrl.sv
`timescale 1ns / 1ps
module fcpu_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output fcpu_pkg::cmd_t cmd
);
    import fcpu_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_PRE  = 9'b000000010,
        ST_MOVE = 9'b000000100,
        ST_SAT  = 9'b000001000,
        ST_WRAP = 9'b000010000,
        ST_CYAW = 9'b000100000,
        ST_CPIT = 9'b001000000,
        ST_VEC  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       publish;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign publish   = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    // Sequence one transaction through the datapath
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 5'd1;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = 5'd0;
                if (in_valid)
                begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE:
            begin
                cnt_next   = 5'd0;
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                if (cnt_reg == 5'd5)
                begin
                    cnt_next   = 5'd0;
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                cnt_next   = 5'd0;
                state_next = ST_WRAP;
            end
            ST_WRAP:
            begin
                if (cnt_reg == 5'(WRAP_STEPS - 1))
                begin
                    cnt_next   = 5'd0;
                    state_next = ST_CYAW;
                end
            end
            ST_CYAW:
            begin
                if (cnt_reg == 5'(CORDIC_STEPS + 1))
                begin
                    cnt_next   = 5'd0;
                    state_next = ST_CPIT;
                end
            end
            ST_CPIT:
            begin
                if (cnt_reg == 5'(CORDIC_STEPS + 1))
                begin
                    cnt_next   = 5'd0;
                    state_next = ST_VEC;
                end
            end
            ST_VEC:
            begin
                if (cnt_reg == 5'd3)
                begin
                    cnt_next   = 5'd0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                cnt_next = 5'd0;
                if (publish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                cnt_next   = 5'd0;
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the consumer takes it
    always_comb
    begin
        if (publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Decode commands
    always_comb
    begin
        cmd         = '0;
        cmd.cnt     = cnt_reg;
        cmd.load    = (state_reg == ST_IDLE) && in_valid;
        cmd.pre     = (state_reg == ST_PRE);
        cmd.move    = (state_reg == ST_MOVE);
        cmd.sat     = (state_reg == ST_SAT);
        cmd.wrap    = (state_reg == ST_WRAP);
        cmd.csel    = (state_reg == ST_CPIT);
        cmd.vmul    = (state_reg == ST_VEC);
        cmd.publish = publish;
        if ((state_reg == ST_CYAW) || (state_reg == ST_CPIT))
        begin
            cmd.cinit  = (cnt_reg == 5'd0);
            cmd.cstep  = cnt_reg inside {[5'd1:5'(CORDIC_STEPS)]};
            cmd.cstore = (cnt_reg == 5'(CORDIC_STEPS + 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/fcpu_datapath.sv
`timescale 1ns / 1ps
module fcpu_datapath #(
    parameter int POSITION_WIDTH = 32,
    parameter int VECTOR_WIDTH   = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fcpu_pkg::cmd_t                   cmd,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [15:0]                      cfg_data,
    input  logic                             move_forward,
    input  logic                             move_back,
    input  logic                             strafe_right,
    input  logic                             strafe_left,
    input  logic                             move_up,
    input  logic                             move_down,
    input  logic                             sprint,
    input  logic [15:0]                      delta_time,
    input  logic signed [15:0]               mouse_dx,
    input  logic signed [15:0]               mouse_dy,
    output logic signed [POSITION_WIDTH-1:0] pos_x,
    output logic signed [POSITION_WIDTH-1:0] pos_y,
    output logic signed [POSITION_WIDTH-1:0] pos_z,
    output logic signed [VECTOR_WIDTH-1:0]   front_x,
    output logic signed [VECTOR_WIDTH-1:0]   front_y,
    output logic signed [VECTOR_WIDTH-1:0]   front_z,
    output logic signed [VECTOR_WIDTH-1:0]   right_x,
    output logic signed [VECTOR_WIDTH-1:0]   right_y,
    output logic signed [VECTOR_WIDTH-1:0]   right_z,
    output logic signed [VECTOR_WIDTH-1:0]   up_x,
    output logic signed [VECTOR_WIDTH-1:0]   up_y,
    output logic signed [VECTOR_WIDTH-1:0]   up_z
);
    import fcpu_pkg::*;

    localparam int PW   = POSITION_WIDTH;
    localparam int VW   = VECTOR_WIDTH;
    localparam int FRAC = VW - 2;
    localparam int CSH  = 32 - VW;
    localparam int MAW  = (VW > 25) ? VW : 25;
    localparam int PRW  = MAW + VW;
    localparam int DW   = 28;
    localparam int SW   = ((PW > DW) ? PW : DW) + 1;

    localparam logic signed [VW-1:0]  ONE_V   = VW'(1) <<< FRAC;
    localparam logic signed [33:0]    ONE_C   = 34'sd1 <<< FRAC;
    localparam logic signed [33:0]    CHALF   =
        (CSH == 0) ? 34'sd0 : (34'sd1 <<< ((CSH == 0) ? 0 : CSH - 1));
    localparam logic signed [PRW-1:0] MHALF   = PRW'(1) <<< (FRAC - 1);
    localparam logic signed [SW-1:0]  PMAX    = SW'({1'b0, {(PW - 1){1'b1}}});
    localparam logic signed [SW-1:0]  PMIN    = -PMAX - SW'(1);
    localparam logic signed [PW-1:0]  POS_Z0  = PW'(3) <<< 16;

    // Configuration and latched item
    logic [15:0]        walk_reg, sprint_reg, sens_reg;
    logic [6:0]         keys_reg;
    logic [15:0]        dt_reg;
    logic signed [15:0] mdx_reg, mdy_reg;

    // Pose state
    logic signed [PW-1:0] pos_reg   [3];
    logic signed [VW-1:0] front_reg [3];
    logic signed [VW-1:0] right_reg [3];
    logic signed [VW-1:0] up_reg    [3];
    logic [15:0]          yaw_reg;
    logic signed [14:0]   pitch_reg;

    // Work registers
    logic [23:0]          vel_reg;
    logic signed [DW-1:0] disp_reg [3];
    logic [24:0]          yaw_acc_reg;
    logic signed [33:0]   crx_reg, cry_reg;
    logic signed [31:0]   crz_reg;
    logic signed [VW-1:0] cosy_reg, siny_reg, cosp_reg, sinp_reg;

    // Output registers
    logic signed [PW-1:0] pos_out_reg   [3];
    logic signed [VW-1:0] front_out_reg [3];
    logic signed [VW-1:0] right_out_reg [3];
    logic signed [VW-1:0] up_out_reg    [3];

    // Velocity and angle increments
    logic [15:0]        speed;
    logic [31:0]        vel_prod;
    logic [23:0]        vel_next;
    logic signed [32:0] yaw_prod, pitch_prod;
    logic signed [23:0] yaw_inc, pitch_inc;
    logic signed [25:0] yaw_sum;
    logic [24:0]        yaw_start;
    logic signed [24:0] pitch_sum;
    logic signed [14:0] pitch_next;

    always_comb
    begin
        speed      = keys_reg[6] ? sprint_reg : walk_reg;
        vel_prod   = speed * dt_reg;
        vel_next   = 24'((vel_prod + 32'd128) >> 8);
        yaw_prod   = 33'(mdx_reg) * 33'($signed({1'b0, sens_reg}));
        pitch_prod = 33'(mdy_reg) * 33'($signed({1'b0, sens_reg}));
        yaw_inc    = 24'((yaw_prod + 33'sd256) >>> 9);
        pitch_inc  = 24'((pitch_prod + 33'sd256) >>> 9);
        yaw_sum    = 26'($signed({1'b0, yaw_reg})) + 26'(yaw_inc);
        yaw_start  = (yaw_sum < 0) ? 25'(yaw_sum + YAW_BIAS) : 25'(yaw_sum);
        pitch_sum  = 25'(pitch_reg) + 25'(pitch_inc);
        if (pitch_sum > PITCH_LIMIT)
        begin
            pitch_next = 15'(PITCH_LIMIT);
        end
        else if (pitch_sum < -PITCH_LIMIT)
        begin
            pitch_next = 15'(-PITCH_LIMIT);
        end
        else
        begin
            pitch_next = 15'(pitch_sum);
        end
    end

    // Shared multiplier with round to nearest
    logic [2:0]            mstep;
    logic [1:0]            maxis;
    logic signed [MAW-1:0] mul_a;
    logic signed [VW-1:0]  mul_b;
    logic signed [PRW-1:0] mul_p, mul_r;
    logic signed [DW-1:0]  move_term;
    logic                  move_en, move_neg;

    always_comb
    begin
        mstep = cmd.cnt[2:0];
        maxis = mstep[2:1];
        if (cmd.vmul)
        begin
            mul_a = MAW'(cmd.cnt[0] ? siny_reg : cosy_reg);
            mul_b = cmd.cnt[1] ? sinp_reg : cosp_reg;
        end
        else
        begin
            mul_a = MAW'($signed({1'b0, vel_reg}));
            mul_b = mstep[0] ? right_reg[maxis] : front_reg[maxis];
        end
        mul_p     = PRW'(mul_a) * PRW'(mul_b);
        mul_r     = (mul_p + MHALF) >>> FRAC;
        move_en   = mstep[0] ? (keys_reg[2] | keys_reg[3]) : (keys_reg[0] | keys_reg[1]);
        move_neg  = mstep[0] ? !keys_reg[2] : !keys_reg[0];
        move_term = move_neg ? -DW'(mul_r) : DW'(mul_r);
    end

    // Saturating position add
    logic signed [SW-1:0] psum [3];
    logic signed [PW-1:0] psat [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            psum[k] = SW'(pos_reg[k]) + SW'(disp_reg[k]);
            if (psum[k] > PMAX)
            begin
                psat[k] = PW'(PMAX);
            end
            else if (psum[k] < PMIN)
            begin
                psat[k] = PW'(PMIN);
            end
            else
            begin
                psat[k] = PW'(psum[k]);
            end
        end
    end

    // Yaw wrap: one restoring subtract of a shifted full turn per step
    logic [24:0] wrap_sub;
    logic [3:0]  wrap_shift;

    always_comb
    begin
        wrap_shift = 4'(WRAP_STEPS - 1) - cmd.cnt[3:0];
        wrap_sub   = 25'(YAW_FULL) << wrap_shift;
    end

    // Fold yaw into plus or minus a quarter turn
    logic [17:0]        yaw_in, yaw_fold_src;
    logic signed [17:0] yaw_angle;
    logic               yaw_neg;
    logic signed [17:0] cangle;

    always_comb
    begin
        yaw_in       = {2'b00, yaw_acc_reg[15:0]};
        yaw_fold_src = {2'b00, yaw_reg};
        if ((yaw_in > YAW_QUARTER) && (yaw_in < YAW_THREE_QUARTER))
        begin
            yaw_angle = $signed(yaw_in - YAW_HALF);
        end
        else if (yaw_in >= YAW_THREE_QUARTER)
        begin
            yaw_angle = $signed(yaw_in - 18'(YAW_FULL));
        end
        else
        begin
            yaw_angle = $signed(yaw_in);
        end
        yaw_neg = (yaw_fold_src > YAW_QUARTER) && (yaw_fold_src < YAW_THREE_QUARTER);
        cangle  = cmd.csel ? 18'(pitch_reg) : yaw_angle;
    end

    // CORDIC rotation step and result rounding
    logic [3:0]           ci;
    logic signed [33:0]   cdx, cdy;
    logic signed [31:0]   catan;
    logic signed [33:0]   crnd_x, crnd_y;
    logic signed [VW-1:0] ccos, csin;

    always_comb
    begin
        ci     = 4'(cmd.cnt - 5'd1);
        cdx    = cry_reg >>> ci;
        cdy    = crx_reg >>> ci;
        catan  = atan_lut(ci);
        crnd_x = (crx_reg + CHALF) >>> CSH;
        crnd_y = (cry_reg + CHALF) >>> CSH;
        if (crnd_x > ONE_C)
        begin
            ccos = ONE_V;
        end
        else if (crnd_x < -ONE_C)
        begin
            ccos = -ONE_V;
        end
        else
        begin
            ccos = VW'(crnd_x);
        end
        if (crnd_y > ONE_C)
        begin
            csin = ONE_V;
        end
        else if (crnd_y < -ONE_C)
        begin
            csin = -ONE_V;
        end
        else
        begin
            csin = VW'(crnd_y);
        end
    end

    // Configuration and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg     <= WALK_SPEED_RESET;
            sprint_reg   <= SPRINT_SPEED_RESET;
            sens_reg     <= MOUSE_SENS_RESET;
            pos_reg[0]   <= '0;
            pos_reg[1]   <= '0;
            pos_reg[2]   <= POS_Z0;
            yaw_reg      <= YAW_RESET;
            pitch_reg    <= '0;
            front_reg[0] <= '0;
            front_reg[1] <= '0;
            front_reg[2] <= -ONE_V;
            right_reg[0] <= ONE_V;
            right_reg[1] <= '0;
            right_reg[2] <= '0;
            up_reg[0]    <= '0;
            up_reg[1]    <= ONE_V;
            up_reg[2]    <= '0;
        end
        else
        begin
            // Drop writes to unused indexes
            if (cfg_we)
            begin
                if (cfg_index == REG_WALK_SPEED)
                begin
                    walk_reg <= cfg_data;
                end
                if (cfg_index == REG_SPRINT_SPEED)
                begin
                    sprint_reg <= cfg_data;
                end
                if (cfg_index == REG_MOUSE_SENS)
                begin
                    sens_reg <= cfg_data;
                end
            end
            if (cmd.pre)
            begin
                pitch_reg <= pitch_next;
            end
            if (cmd.sat)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pos_reg[k] <= psat[k];
                end
            end
            if (cmd.cinit && !cmd.csel)
            begin
                yaw_reg <= yaw_acc_reg[15:0];
            end
            // Rebuild the basis from yaw and pitch
            if (cmd.vmul)
            begin
                case (cmd.cnt[1:0])
                    2'd0:
                    begin
                        front_reg[0] <= VW'(mul_r);
                        front_reg[1] <= sinp_reg;
                        right_reg[0] <= -siny_reg;
                        right_reg[1] <= '0;
                        right_reg[2] <= cosy_reg;
                        up_reg[1]    <= cosp_reg;
                    end
                    2'd1:    front_reg[2] <= VW'(mul_r);
                    2'd2:    up_reg[0]    <= -VW'(mul_r);
                    default: up_reg[2]    <= -VW'(mul_r);
                endcase
            end
        end
    end

    // Work and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            keys_reg <= {sprint, move_down, move_up, strafe_left, strafe_right,
                         move_back, move_forward};
            dt_reg   <= delta_time;
            mdx_reg  <= mouse_dx;
            mdy_reg  <= mouse_dy;
        end
        if (cmd.pre)
        begin
            vel_reg     <= vel_next;
            yaw_acc_reg <= yaw_start;
            disp_reg[0] <= '0;
            disp_reg[2] <= '0;
            if (keys_reg[4])
            begin
                disp_reg[1] <= DW'(vel_next);
            end
            else if (keys_reg[5])
            begin
                disp_reg[1] <= -DW'(vel_next);
            end
            else
            begin
                disp_reg[1] <= '0;
            end
        end
        if (cmd.move && move_en)
        begin
            disp_reg[maxis] <= disp_reg[maxis] + move_term;
        end
        if (cmd.wrap && (yaw_acc_reg >= wrap_sub))
        begin
            yaw_acc_reg <= yaw_acc_reg - wrap_sub;
        end
        if (cmd.cinit)
        begin
            crx_reg <= CORDIC_GAIN_INV;
            cry_reg <= '0;
            crz_reg <= 32'(cangle) <<< 13;
        end
        if (cmd.cstep)
        begin
            if (crz_reg >= 0)
            begin
                crx_reg <= crx_reg - cdx;
                cry_reg <= cry_reg + cdy;
                crz_reg <= crz_reg - catan;
            end
            else
            begin
                crx_reg <= crx_reg + cdx;
                cry_reg <= cry_reg - cdy;
                crz_reg <= crz_reg + catan;
            end
        end
        if (cmd.cstore)
        begin
            if (cmd.csel)
            begin
                cosp_reg <= ccos;
                sinp_reg <= csin;
            end
            else
            begin
                cosy_reg <= yaw_neg ? -ccos : ccos;
                siny_reg <= yaw_neg ? -csin : csin;
            end
        end
        if (cmd.publish)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pos_out_reg[k]   <= pos_reg[k];
                front_out_reg[k] <= front_reg[k];
                right_out_reg[k] <= right_reg[k];
                up_out_reg[k]    <= up_reg[k];
            end
        end
    end

    assign pos_x   = pos_out_reg[0];
    assign pos_y   = pos_out_reg[1];
    assign pos_z   = pos_out_reg[2];
    assign front_x = front_out_reg[0];
    assign front_y = front_out_reg[1];
    assign front_z = front_out_reg[2];
    assign right_x = right_out_reg[0];
    assign right_y = right_out_reg[1];
    assign right_z = right_out_reg[2];
    assign up_x    = up_out_reg[0];
    assign up_y    = up_out_reg[1];
    assign up_z    = up_out_reg[2];

endmodule

// File: hw/rtl/fly_camera_pose_update_core.sv
// From input acceptance to out_valid, a transaction runs the 6 moves through one
// multiplier, the 10-step yaw wrap and the two 16-step CORDIC passes.
// A new transaction is taken only once the last is published; a finished result waits in the
// output register while the next transaction is accepted.
// Reset (rst_n low, asynchronous): pose returns to (0, 0, 3), yaw 270, pitch 0,
// speeds and sensitivity to their defaults, no result pending.
`timescale 1ns / 1ps
module fly_camera_pose_update_core #(
    parameter int POSITION_WIDTH = 32,
    parameter int VECTOR_WIDTH   = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [15:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             move_forward,
    input  logic                             move_back,
    input  logic                             strafe_right,
    input  logic                             strafe_left,
    input  logic                             move_up,
    input  logic                             move_down,
    input  logic                             sprint,
    input  logic [15:0]                      delta_time,
    input  logic signed [15:0]               mouse_dx,
    input  logic signed [15:0]               mouse_dy,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [POSITION_WIDTH-1:0] pos_x,
    output logic signed [POSITION_WIDTH-1:0] pos_y,
    output logic signed [POSITION_WIDTH-1:0] pos_z,
    output logic signed [VECTOR_WIDTH-1:0]   front_x,
    output logic signed [VECTOR_WIDTH-1:0]   front_y,
    output logic signed [VECTOR_WIDTH-1:0]   front_z,
    output logic signed [VECTOR_WIDTH-1:0]   right_x,
    output logic signed [VECTOR_WIDTH-1:0]   right_y,
    output logic signed [VECTOR_WIDTH-1:0]   right_z,
    output logic signed [VECTOR_WIDTH-1:0]   up_x,
    output logic signed [VECTOR_WIDTH-1:0]   up_y,
    output logic signed [VECTOR_WIDTH-1:0]   up_z
);
    import fcpu_pkg::*;

    cmd_t cmd;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    fcpu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    fcpu_datapath #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .VECTOR_WIDTH   (VECTOR_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .move_forward (move_forward),
        .move_back    (move_back),
        .strafe_right (strafe_right),
        .strafe_left  (strafe_left),
        .move_up      (move_up),
        .move_down    (move_down),
        .sprint       (sprint),
        .delta_time   (delta_time),
        .mouse_dx     (mouse_dx),
        .mouse_dy     (mouse_dy),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .front_x      (front_x),
        .front_y      (front_y),
        .front_z      (front_z),
        .right_x      (right_x),
        .right_y      (right_y),
        .right_z      (right_z),
        .up_x         (up_x),
        .up_y         (up_y),
        .up_z         (up_z)
    );

endmodule

// File: hw/rtl/fcpu_checker.sv
`timescale 1ns / 1ps
module fcpu_checker #(
    parameter int VECTOR_WIDTH = 16
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [VECTOR_WIDTH-1:0] front_x,
    input logic [VECTOR_WIDTH-1:0] up_y
);
    localparam logic signed [VECTOR_WIDTH:0] ONE = (VECTOR_WIDTH + 1)'(1) <<< (VECTOR_WIDTH - 2);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Go busy after each accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // A new result appears only as the block returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready && !$past(in_ready))
        else $error("result published outside the end of a transaction");

    // front_x stays within unit range and up_y within zero to one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(front_x) <= ONE) && ($signed(front_x) >= -ONE)
                   && ($signed(up_y) <= ONE) && ($signed(up_y) >= 0))
        else $error("basis component out of range");

endmodule

bind fly_camera_pose_update_core fcpu_checker #(
    .VECTOR_WIDTH (VECTOR_WIDTH)
) u_fcpu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .front_x   (front_x),
    .up_y      (up_y)
);
